>>> rtl/core/rgch_pkg.sv
// Shared types, constants and the dB threshold table for the receive gain control.
// No dependencies; every other file in rtl/core imports this package.
package rgch_pkg;

    localparam int NUM_RX_ANT = 2;
    localparam int ANT_USED   = (NUM_RX_ANT < 1) ? 1 : ((NUM_RX_ANT > 4) ? 4 : NUM_RX_ANT);

    localparam int PWR_W   = 30;
    localparam int DB_W    = 7;
    localparam int GAIN_W  = 7;
    localparam int COEF_W  = 11;
    localparam int CFG_W   = 11;
    localparam int PROD_W  = PWR_W + COEF_W;
    localparam int SHIFT_W = 10;
    localparam int DB_LEN  = 90;

    localparam logic [COEF_W-1:0] COEF_ONE = 11'd1024;
    localparam logic [GAIN_W:0]   STEP_DB  = 8'd5;
    localparam logic [DB_W:0]     HYST_DB  = 8'd5;
    localparam logic [GAIN_W:0]   GAIN_TOP = 8'd127;

    localparam logic [COEF_W-1:0] COEF_RST     = 11'd960;
    localparam logic [DB_W-1:0]   TARGET_RST   = 7'd60;
    localparam logic [GAIN_W-1:0] MAX_GAIN_RST = 7'd100;
    localparam logic [GAIN_W-1:0] MIN_GAIN_RST = 7'd0;

    // Smallest linear power that reaches d dB, for d = 1 .. 90.
    localparam logic [PWR_W-1:0] DB_THR [DB_LEN] = '{
        30'd2, 30'd2, 30'd2, 30'd3, 30'd4, 30'd4, 30'd6, 30'd7, 30'd8, 30'd10,
        30'd13, 30'd16, 30'd20, 30'd26, 30'd32, 30'd40, 30'd51, 30'd64, 30'd80, 30'd100,
        30'd126, 30'd159, 30'd200, 30'd252, 30'd317, 30'd399, 30'd502, 30'd631, 30'd795,
        30'd1000,
        30'd1259, 30'd1585, 30'd1996, 30'd2512, 30'd3163, 30'd3982, 30'd5012, 30'd6310,
        30'd7944, 30'd10000,
        30'd12590, 30'd15849, 30'd19953, 30'd25119, 30'd31623, 30'd39811, 30'd50119,
        30'd63096, 30'd79433, 30'd100000,
        30'd125893, 30'd158490, 30'd199527, 30'd251189, 30'd316228, 30'd398108, 30'd501188,
        30'd630958, 30'd794329, 30'd1000000,
        30'd1258926, 30'd1584894, 30'd1995263, 30'd2511887, 30'd3162278, 30'd3981072,
        30'd5011873, 30'd6309574, 30'd7943283, 30'd10000000,
        30'd12589255, 30'd15848932, 30'd19952624, 30'd25118865, 30'd31622777, 30'd39810718,
        30'd50118724, 30'd63095735, 30'd79432824, 30'd100000000,
        30'd125892542, 30'd158489320, 30'd199526232, 30'd251188644, 30'd316227767,
        30'd398107171, 30'd501187234, 30'd630957345, 30'd794328235, 30'd1000000000
    };

    typedef enum logic [1:0] {
        CFG_COEF     = 2'd0,
        CFG_TARGET   = 2'd1,
        CFG_MAX_GAIN = 2'd2,
        CFG_MIN_GAIN = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [COEF_W-1:0] coef;
        logic [DB_W-1:0]   target;
        logic [GAIN_W-1:0] max_gain;
        logic [GAIN_W-1:0] min_gain;
    } cfg_t;

    typedef struct packed {
        logic             clear;
        logic [PWR_W-1:0] peak;
    } q_item_t;

    typedef struct packed {
        logic valid;
        logic pop;
    } q_ctrl_t;

    typedef enum logic [1:0] {
        CHG_NONE = 2'd0,
        CHG_UP   = 2'd1,
        CHG_DOWN = 2'd2
    } change_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_CMP,
        ST_DB
    } bk_state_t;

endpackage

>>> rtl/core/rgch_front.sv
// Front end: takes input transfers and reduces the antenna powers to one peak.
// Depends on rgch_pkg; feeds rgch_queue.
module rgch_front
    import rgch_pkg::*;
(
    input  logic             clear_filter,
    input  logic [PWR_W-1:0] power_ant0,
    input  logic [PWR_W-1:0] power_ant1,
    input  logic [PWR_W-1:0] power_ant2,
    input  logic [PWR_W-1:0] power_ant3,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             q_full,
    output logic             q_push,
    output q_item_t          q_item
);

    logic [PWR_W-1:0] pwr [4];
    logic [PWR_W-1:0] peak;

    assign pwr[0] = power_ant0;
    assign pwr[1] = power_ant1;
    assign pwr[2] = power_ant2;
    assign pwr[3] = power_ant3;

    // Antennas beyond the configured count never take part.
    always_comb
    begin
        peak = pwr[0];
        for (int i = 1; i < ANT_USED; i++)
        begin
            if (pwr[i] > peak)
            begin
                peak = pwr[i];
            end
        end
    end

    assign in_ready     = !q_full;
    assign q_push       = in_valid && !q_full;
    assign q_item.clear = clear_filter;
    assign q_item.peak  = peak;

endmodule

>>> rtl/core/rgch_queue.sv
// Two-entry queue between the front end and the filter/gain sequencer.
// Depends on rgch_pkg for the item type.
module rgch_queue
    import rgch_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  q_item_t push_item,
    output logic    full,
    input  logic    pop,
    output logic    not_empty,
    output q_item_t head
);

    q_item_t    mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/core/rgch_back.sv
// Back end: smoothing filter, dB conversion and gain stepping, with the output register.
// Depends on rgch_pkg; pops items from rgch_queue.
module rgch_back
    import rgch_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  q_item_t           head,
    output q_ctrl_t           qc,
    input  logic              q_not_empty,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [GAIN_W-1:0] gain_db,
    output logic [PWR_W-1:0]  filtered_power,
    output logic [DB_W-1:0]   filtered_power_db,
    output logic [1:0]        gain_change
);

    bk_state_t         state_reg;
    bk_state_t         state_next;
    logic              pop;
    logic              fin;
    logic              out_free;

    q_item_t           item_reg;
    logic [PROD_W-1:0] prod_old_reg;
    logic [PROD_W-1:0] prod_new_reg;
    logic [PWR_W-1:0]  smooth_reg;
    logic [DB_LEN-1:0] therm_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic              out_valid_reg;
    logic [GAIN_W-1:0] out_gain_reg;
    logic [PWR_W-1:0]  out_power_reg;
    logic [DB_W-1:0]   out_db_reg;
    change_t           out_change_reg;

    logic [COEF_W-1:0] coef_sat;
    logic [PROD_W:0]   acc_sum;
    logic [DB_W-1:0]   db_val;
    logic              step_up;
    logic              step_down;
    logic [GAIN_W:0]   gain_plus;
    logic [GAIN_W-1:0] gain_new;
    change_t           change_new;

    assign out_free = !out_valid_reg || out_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_not_empty)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: state_next = ST_ACC;
            ST_ACC: state_next = ST_CMP;
            ST_CMP: state_next = ST_DB;
            ST_DB:
            begin
                if (out_free)
                begin
                    state_next = q_not_empty ? ST_MUL : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: a new item is taken as soon as the previous one retires.
    always_comb
    begin
        fin = (state_reg == ST_DB) && out_free;
        pop = q_not_empty && ((state_reg == ST_IDLE) || fin);
    end

    assign qc.valid = q_not_empty;
    assign qc.pop   = pop;

    // A coefficient above one leaves the filter holding its old value.
    assign coef_sat = (cfg.coef > COEF_ONE) ? COEF_ONE : cfg.coef;
    assign acc_sum  = {1'b0, prod_old_reg} + {1'b0, prod_new_reg};

    always_comb
    begin
        db_val = '0;
        for (int i = 0; i < DB_LEN; i++)
        begin
            if (therm_reg[i])
            begin
                db_val = DB_W'(i + 1);
            end
        end
    end

    assign step_up   = (({1'b0, db_val} + HYST_DB) < {1'b0, cfg.target})
                       && (gain_reg < cfg.max_gain);
    assign step_down = ({1'b0, db_val} > ({1'b0, cfg.target} + HYST_DB))
                       && (gain_reg > cfg.min_gain);
    assign gain_plus = {1'b0, gain_reg} + STEP_DB;

    // The step up is tested first; the two dB conditions exclude each other, so inverted limits still resolve one way.
    always_comb
    begin
        priority if (step_up)
        begin
            gain_new   = (gain_plus > GAIN_TOP) ? GAIN_TOP[GAIN_W-1:0]
                                                : gain_plus[GAIN_W-1:0];
            change_new = CHG_UP;
        end
        else if (step_down)
        begin
            gain_new   = (gain_reg < STEP_DB[GAIN_W-1:0]) ? '0
                                                         : gain_reg - STEP_DB[GAIN_W-1:0];
            change_new = CHG_DOWN;
        end
        else
        begin
            gain_new   = gain_reg;
            change_new = CHG_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= head;
        end
        if (state_reg == ST_MUL)
        begin
            prod_old_reg <= smooth_reg * coef_sat;
            prod_new_reg <= item_reg.peak * (COEF_ONE - coef_sat);
        end
        if (state_reg == ST_CMP)
        begin
            for (int i = 0; i < DB_LEN; i++)
            begin
                therm_reg[i] <= (smooth_reg >= DB_THR[i]);
            end
        end
        if (fin)
        begin
            out_gain_reg   <= gain_new;
            out_power_reg  <= smooth_reg;
            out_db_reg     <= db_val;
            out_change_reg <= change_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            smooth_reg    <= '0;
            gain_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_ACC)
            begin
                smooth_reg <= item_reg.clear ? item_reg.peak
                                             : acc_sum[SHIFT_W +: PWR_W];
            end
            if (fin)
            begin
                gain_reg      <= gain_new;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign gain_db           = out_gain_reg;
    assign filtered_power    = out_power_reg;
    assign filtered_power_db = out_db_reg;
    assign gain_change       = out_change_reg;

    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_not_empty)
        else $error("queue popped while empty");

    a_seq_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |=> (state_reg == ST_ACC))
        else $error("sequencer skipped the accumulate step");

    a_gain_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> $stable(gain_reg))
        else $error("gain moved while a result was stalled");

    a_out_matches_gain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_gain_reg == gain_reg))
        else $error("pending result disagrees with stored gain");

endmodule

>>> rtl/core/rx_gain_control_hysteresis.sv
// Top level of the receive gain control: configuration registers and the three stages.
// Depends on rgch_pkg, rgch_front, rgch_queue and rgch_back.

// Each input transfer carries per-antenna linear power and a clear flag; the block keeps
// the peak over the antennas in use, smooths it with a first-order filter (or loads it
// when clear_filter is high), converts it to integer dB and steps the gain by 5 dB with
// 5 dB hysteresis, giving one result per input. The filter/gain sequencer works on one
// item at a time (multiply, accumulate, threshold compare, dB encode and gain step) and
// waits in the dB step while the result register holds an unread result. A two-entry
// queue lets inputs be taken while the sequencer works, and the result register lets the
// next item proceed while a result waits.
// Configuration writes must happen only while no item is in flight.
module rx_gain_control_hysteresis
    import rgch_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              clear_filter,
    input  logic [PWR_W-1:0]  power_ant0,
    input  logic [PWR_W-1:0]  power_ant1,
    input  logic [PWR_W-1:0]  power_ant2,
    input  logic [PWR_W-1:0]  power_ant3,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [GAIN_W-1:0] gain_db,
    output logic [PWR_W-1:0]  filtered_power,
    output logic [DB_W-1:0]   filtered_power_db,
    output logic [1:0]        gain_change
);

    cfg_t    cfg_reg;
    logic    q_full;
    logic    q_push;
    logic    q_not_empty;
    q_item_t q_in;
    q_item_t q_head;
    q_ctrl_t qc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coef     <= COEF_RST;
            cfg_reg.target   <= TARGET_RST;
            cfg_reg.max_gain <= MAX_GAIN_RST;
            cfg_reg.min_gain <= MIN_GAIN_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_COEF:     cfg_reg.coef     <= cfg_wdata;
                CFG_TARGET:   cfg_reg.target   <= cfg_wdata[DB_W-1:0];
                CFG_MAX_GAIN: cfg_reg.max_gain <= cfg_wdata[GAIN_W-1:0];
                CFG_MIN_GAIN: cfg_reg.min_gain <= cfg_wdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    rgch_front u_front (
        .clear_filter (clear_filter),
        .power_ant0   (power_ant0),
        .power_ant1   (power_ant1),
        .power_ant2   (power_ant2),
        .power_ant3   (power_ant3),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (q_in)
    );

    rgch_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (qc.pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    rgch_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg_reg),
        .head              (q_head),
        .qc                (qc),
        .q_not_empty       (q_not_empty),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .gain_db           (gain_db),
        .filtered_power    (filtered_power),
        .filtered_power_db (filtered_power_db),
        .gain_change       (gain_change)
    );

endmodule
